FILE: src/osts_pkg.sv
package osts_pkg;

  // Largest table the slot field can address.
  localparam int unsigned MAX_SLOTS = 8;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_REG    = 2'd1,
    MODE_CANCEL = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    KIND_REGISTERED = 3'd0,
    KIND_FULL       = 3'd1,
    KIND_CANCELLED  = 3'd2,
    KIND_IDLE       = 3'd3,
    KIND_FIRED      = 3'd4
  } kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // latch the input transaction
    logic exec;       // evaluate the latched item
    logic fire_step;  // emit the lowest pending fired slot
  } osts_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
    logic tick_fire;  // latched item is a tick and at least one slot is due
    logic fire_pend;  // fired slots remain to be emitted
    logic fire_last;  // at most one fired slot remains
  } osts_sts_t;

  // Index of the lowest set bit; zero when none is set.
  function automatic logic [2:0] lowest_bit(logic [MAX_SLOTS-1:0] v);
    logic [2:0] idx;
    idx = 3'd0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = 3'(i);
      end
    end
    return idx;
  endfunction

endpackage

FILE: src/osts_ctrl.sv
module osts_ctrl
  import osts_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  osts_sts_t sts,
  output osts_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_FIRE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.out_free) begin
          cmd.exec   = 1'b1;
          state_next = sts.tick_fire ? ST_FIRE : ST_IDLE;
        end
      end
      ST_FIRE: begin
        if (sts.out_free) begin
          cmd.fire_step = 1'b1;
          if (sts.fire_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/osts_dp.sv
module osts_dp
  import osts_pkg::*;
#(
  parameter int unsigned SLOTS  = 8,
  parameter int unsigned SLOT_W = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  osts_cmd_t   cmd,
  output osts_sts_t   sts,
  input  logic [1:0]  mode,
  input  logic [7:0]  tag,
  input  logic [31:0] delay,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [7:0]  tag_res,
  output logic [2:0]  slot,
  output logic        last
);

  // Latched item.
  logic [1:0]  cur_mode;
  logic [7:0]  cur_tag;
  logic [31:0] cur_delay;

  // Timer state.
  logic [31:0]      now;
  logic [SLOTS-1:0] occupied;
  logic [SLOTS-1:0] fire_mask;
  logic [7:0]       slot_tag [SLOTS];
  logic [31:0]      due_time [SLOTS];

  logic [SLOTS-1:0]  due_hit;
  logic [SLOTS-1:0]  tag_hit;
  logic [SLOTS-1:0]  free_mask;
  logic [SLOT_W-1:0] free_idx;
  logic [SLOT_W-1:0] match_idx;
  logic [SLOT_W-1:0] fire_idx;
  logic [SLOTS-1:0]  fire_rest;

  logic       emit;
  logic [2:0] emit_kind;
  logic [7:0] emit_tag;
  logic [2:0] emit_slot;
  logic       emit_last;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      due_hit[i] = occupied[i] && (due_time[i] == now);
      tag_hit[i] = occupied[i] && (slot_tag[i] == cur_tag);
    end
  end

  assign free_mask = ~occupied;
  assign free_idx  = SLOT_W'(lowest_bit(MAX_SLOTS'(free_mask)));
  assign match_idx = SLOT_W'(lowest_bit(MAX_SLOTS'(tag_hit)));
  assign fire_idx  = SLOT_W'(lowest_bit(MAX_SLOTS'(fire_mask)));
  assign fire_rest = fire_mask & (fire_mask - SLOTS'(1));

  assign sts.out_free  = !out_valid || out_ready;
  assign sts.tick_fire = (cur_mode == MODE_TICK) && (due_hit != '0);
  assign sts.fire_pend = (fire_mask != '0);
  assign sts.fire_last = (fire_rest == '0);

  // Result selection for the output register.
  always_comb begin
    emit      = 1'b0;
    emit_kind = KIND_IDLE;
    emit_tag  = 8'd0;
    emit_slot = 3'd0;
    emit_last = 1'b1;
    if (cmd.exec) begin
      case (cur_mode)
        MODE_TICK: begin
          emit = (due_hit == '0);
        end
        MODE_REG: begin
          emit = 1'b1;
          if (free_mask != '0) begin
            emit_kind = KIND_REGISTERED;
            emit_tag  = cur_tag;
            emit_slot = 3'(free_idx);
          end else begin
            emit_kind = KIND_FULL;
          end
        end
        MODE_CANCEL: begin
          emit      = (tag_hit != '0);
          emit_kind = KIND_CANCELLED;
          emit_tag  = cur_tag;
          emit_slot = 3'(match_idx);
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end else if (cmd.fire_step) begin
      emit      = 1'b1;
      emit_kind = KIND_FIRED;
      emit_tag  = slot_tag[fire_idx];
      emit_slot = 3'(fire_idx);
      emit_last = (fire_rest == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now       <= 32'd0;
      occupied  <= '0;
      fire_mask <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load && (mode == MODE_TICK)) begin
        now <= now + 32'd1;
      end
      if (cmd.exec) begin
        case (cur_mode)
          MODE_TICK: begin
            fire_mask <= due_hit;
          end
          MODE_REG: begin
            if (free_mask != '0) begin
              occupied[free_idx] <= 1'b1;
            end
          end
          MODE_CANCEL: begin
            if (tag_hit != '0) begin
              occupied[match_idx] <= 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.fire_step) begin
        fire_mask           <= fire_rest;
        occupied[fire_idx]  <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_mode  <= mode;
      cur_tag   <= tag;
      cur_delay <= delay;
    end
    if (cmd.exec && (cur_mode == MODE_REG) && (free_mask != '0)) begin
      slot_tag[free_idx] <= cur_tag;
      due_time[free_idx] <= now + cur_delay;
    end
    if (emit) begin
      kind    <= emit_kind;
      tag_res <= emit_tag;
      slot    <= emit_slot;
      last    <= emit_last;
    end
  end

endmodule

FILE: src/one_shot_timeout_slot_table.sv
// A registered, full, cancel or quiet-tick result is loaded into the output register when
// its latched item is evaluated; a firing tick first latches its due slots, then emits them.
// Register, cancel and quiet ticks hold the block for its accept and evaluate steps; a tick
// that fires k slots also takes one fire step per slot, one fired result per cycle while the
// output register is free, set by the controller's single evaluate step and its fire sequencer.
// Reset (rst, synchronous, active high) sets now to zero and frees every slot; stored
// tags and due times are not cleared, since only occupied slots are ever read.
module one_shot_timeout_slot_table
  import osts_pkg::*;
#(
  parameter int unsigned SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [7:0]  tag,
  input  logic [31:0] delay,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [7:0]  tag_res,
  output logic [2:0]  slot,
  output logic        last
);

  // Width of a slot index inside the table; at least one bit.
  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  osts_cmd_t cmd;
  osts_sts_t sts;

  // The controller accepts one transaction at a time and sequences its evaluation
  // and, for ticks, the emission of every fired slot in ascending order.
  osts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the clock, the slot table and the output register. The
  // output register lets a new transaction be accepted while a result still waits.
  osts_dp #(
    .SLOTS  (SLOTS),
    .SLOT_W (SLOT_W)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .mode      (mode),
    .tag       (tag),
    .delay     (delay),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .tag_res   (tag_res),
    .slot      (slot),
    .last      (last)
  );

  // After an accepted transaction the block is busy evaluating it.
  a_busy_after_accept : assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted again before the previous item was evaluated");

  // Only fired timeouts can be followed by further results of the same item.
  a_not_last_is_fired : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> (kind == KIND_FIRED))
    else $error("non-final result that is not a fired timeout");

  // The fire sequencer only steps while fired slots remain.
  a_fire_step_pending : assert property (@(posedge clk) disable iff (rst)
    cmd.fire_step |-> sts.fire_pend)
    else $error("fire step with no fired slot pending");

endmodule

FILE: verif/osts_checker.sv
`timescale 1ns / 1ps

module osts_checker
  import osts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [7:0]  tag,
  input  logic [31:0] delay,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  kind,
  input  logic [7:0]  tag_res,
  input  logic [2:0]  slot,
  input  logic        last,
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    kind_t      kind;
    logic [7:0] tag;
    logic [2:0] slot;
    logic       last;
  } timer_result_t;

  timer_result_t        pending_results[$];
  logic [31:0]          tick_count;
  logic [MAX_SLOTS-1:0] slot_busy;
  logic [7:0]           slot_owner [MAX_SLOTS];
  logic [31:0]          slot_due   [MAX_SLOTS];
  int                   err_cnt = 0;

  assign mismatches = err_cnt;

  function automatic void push_result(kind_t k, logic [7:0] t, logic [2:0] s, logic l);
    timer_result_t r;
    r.kind = k;
    r.tag  = t;
    r.slot = s;
    r.last = l;
    pending_results.push_back(r);
  endfunction

  // Applies one accepted transaction to the shadow table and queues what it causes.
  function automatic void update_timer_table(logic [1:0] m, logic [7:0] t, logic [31:0] d);
    logic [MAX_SLOTS-1:0] due_now;
    int                   hit;
    due_now = '0;
    hit     = -1;
    case (m)
      MODE_TICK: begin
        tick_count = tick_count + 32'd1;
        for (int i = 0; i < MAX_SLOTS; i++) begin
          if (slot_busy[i] && slot_due[i] == tick_count) begin
            due_now[i] = 1'b1;
          end
        end
        if (due_now == '0) begin
          push_result(KIND_IDLE, 8'd0, 3'd0, 1'b1);
        end else begin
          for (int i = 0; i < MAX_SLOTS; i++) begin
            if (due_now[i]) begin
              push_result(KIND_FIRED, slot_owner[i], 3'(i), (due_now >> i) == 1);
            end
          end
          slot_busy = slot_busy & ~due_now;
        end
      end
      MODE_REG: begin
        for (int i = 0; i < MAX_SLOTS; i++) begin
          if (!slot_busy[i] && hit < 0) begin
            hit = i;
          end
        end
        if (hit >= 0) begin
          slot_busy[hit]  = 1'b1;
          slot_owner[hit] = t;
          slot_due[hit]   = tick_count + d;
          push_result(KIND_REGISTERED, t, 3'(hit), 1'b1);
        end else begin
          push_result(KIND_FULL, 8'd0, 3'd0, 1'b1);
        end
      end
      MODE_CANCEL: begin
        // Only occupied slots may match; a stale tag in a free slot is ignored.
        for (int i = 0; i < MAX_SLOTS; i++) begin
          if (slot_busy[i] && slot_owner[i] == t && hit < 0) begin
            hit = i;
          end
        end
        if (hit >= 0) begin
          slot_busy[hit] = 1'b0;
          push_result(KIND_CANCELLED, t, 3'(hit), 1'b1);
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    timer_result_t want;
    if (rst) begin
      tick_count = 32'd0;
      slot_busy  = '0;
      pending_results.delete();
    end else begin
      // Results leaving now come from earlier transactions, so check before predicting.
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual kind %0h tag %0h slot %0h last %0b",
                   $time, kind, tag_res, slot, last);
          err_cnt++;
        end else begin
          want = pending_results.pop_front();
          compare_field("kind", 8'(want.kind), 8'(kind));
          compare_field("tag_res", want.tag, tag_res);
          compare_field("slot", 8'(want.slot), 8'(slot));
          compare_field("last", 8'(want.last), 8'(last));
        end
      end
      if (in_valid && in_ready) begin
        update_timer_table(mode, tag, delay);
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

// Top of the timeout table bench. It makes the request stream and the result-side
// backpressure; the checker beside the block predicts and compares every transaction.
module testbench;
  import osts_pkg::*;

  // Mode value the block must ignore.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Cycles without any transaction before the run is declared hung. The longest
  // legitimate quiet stretch comes from the receiver hold-off below.
  localparam int HANG_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int ITEMS_PER_PHASE = 125;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  mode;
  logic [7:0]  tag;
  logic [31:0] delay;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  kind;
  logic [7:0]  tag_res;
  logic [2:0]  slot;
  logic        last;

  int mismatches;
  int outstanding;
  int send_idle = 0;   // percent of cycles the request side sits idle
  int recv_stall = 0;  // percent of cycles the result side refuses
  bit hold_req = 1'b0; // asks the result side for one long hold-off
  int issued;          // requests sent in the current phase
  int quiet_cycles = 0;

  one_shot_timeout_slot_table #(
    .SLOTS(MAX_SLOTS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .mode     (mode),
    .tag      (tag),
    .delay    (delay),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind     (kind),
    .tag_res  (tag_res),
    .slot     (slot),
    .last     (last)
  );

  osts_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .tag        (tag),
    .delay      (delay),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .tag_res    (tag_res),
    .slot       (slot),
    .last       (last),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random stalls at the phase's rate. When a hold-off is requested,
  // this process counts it down itself while the request side keeps pushing, so the
  // block backs up and has to drop in_ready.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall);
      end
    end
  end

  // Hang detector: any cycle with a transaction on either channel resets the count.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= HANG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, HANG_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Offers one request and returns right after the edge that accepts it. Valid is
  // only lowered when an idle cycle is inserted, so back-to-back requests keep it high.
  task automatic send(input logic [1:0] m, input logic [7:0] t, input logic [31:0] d);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    tag      <= t;
    delay    <= d;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops offering and waits until the checker has seen every predicted result,
  // then gives the block a few more cycles in case the last request caused none.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (6) @(posedge clk);
  endtask

  // Tags mostly come from a small pool so that cancels find their target and
  // duplicates occur; the rest span the whole byte.
  function automatic logic [7:0] pick_tag();
    if ($urandom_range(0, 3) != 0) begin
      return 8'($urandom_range(0, 7));
    end
    return 8'($urandom);
  endfunction

  // Short delays fire within the run; a few long or zero delays park a slot until
  // a cancel frees it, which also lets the table fill up now and then.
  function automatic logic [31:0] pick_delay();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) begin
      return 32'($urandom_range(1, 16));
    end else if (r < 95) begin
      return $urandom;
    end
    return 32'd0;
  endfunction

  // One random step of the stream. A burst registers several timeouts with the same
  // delay and then ticks until they all fire together, which exercises the
  // multi-result path with its last flag.
  task automatic random_step();
    int          r;
    int          n;
    logic [31:0] d;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      n = $urandom_range(2, MAX_SLOTS);
      d = 32'($urandom_range(1, 6));
      repeat (n) begin
        send(MODE_REG, pick_tag(), d);
        issued++;
      end
      repeat (d) begin
        send(MODE_TICK, 8'($urandom), $urandom);
        issued++;
      end
    end else if (r < 60) begin
      send(MODE_TICK, 8'($urandom), $urandom);
      issued++;
    end else if (r < 84) begin
      send(MODE_REG, pick_tag(), pick_delay());
      issued++;
    end else if (r < 97) begin
      send(MODE_CANCEL, pick_tag(), $urandom);
      issued++;
    end else begin
      // Ignored by the block, so it does not count toward the phase.
      send(MODE_UNUSED, 8'($urandom), $urandom);
    end
  endtask

  initial begin
    in_valid <= 1'b0;
    mode     <= MODE_TICK;
    tag      <= 8'd0;
    delay    <= 32'd0;
    rst      <= 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part, run without idling. Registers happen at now = 1, so a delay
    // of k is due on tick number k + 1.
    send(MODE_TICK, 8'h00, 32'h0000_0000);        // nothing due
    send(MODE_CANCEL, 8'h55, 32'h0000_0000);      // cancel on an empty table
    send(MODE_UNUSED, 8'hFF, 32'hFFFF_FFFF);      // ignored mode
    send(MODE_REG, 8'h00, 32'h0000_0000);         // zero delay, wraps the full range
    send(MODE_REG, 8'hFF, 32'hFFFF_FFFF);         // largest delay
    send(MODE_REG, 8'hA5, 32'd3);
    send(MODE_REG, 8'h5A, 32'd3);
    send(MODE_REG, 8'h5A, 32'd2);                 // same tag in a second slot
    send(MODE_REG, 8'h11, 32'h8000_0000);
    send(MODE_REG, 8'h22, 32'd1);
    send(MODE_REG, 8'h33, 32'd3);                 // last free slot
    send(MODE_REG, 8'h44, 32'd5);                 // table full
    send(MODE_CANCEL, 8'h5A, 32'hFFFF_FFFF);      // lowest of the two matches goes
    send(MODE_TICK, 8'hFF, 32'hFFFF_FFFF);        // one slot fires
    send(MODE_TICK, 8'h00, 32'h0000_0000);        // the other 5A fires
    send(MODE_TICK, 8'h00, 32'h0000_0000);        // two slots fire together
    send(MODE_CANCEL, 8'h00, 32'h0000_0000);
    send(MODE_CANCEL, 8'hFF, 32'h0000_0000);
    send(MODE_CANCEL, 8'h11, 32'h0000_0000);
    send(MODE_CANCEL, 8'h11, 32'h0000_0000);      // its slot is free now, no match
    send(MODE_TICK, 8'hFF, 32'hFFFF_FFFF);        // unused fields set, nothing due
    drain_results();

    // Random phases: no idling with a long result hold-off, request side idle,
    // result side stalling, then both.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle = 0;
          recv_stall = 0;
          hold_req = 1'b1;
        end
        1: begin
          send_idle = 63;
          recv_stall = 0;
        end
        2: begin
          send_idle = 0;
          recv_stall = 63;
        end
        default: begin
          send_idle = 38;
          recv_stall = 38;
        end
      endcase
      issued = 0;
      while (issued < ITEMS_PER_PHASE) begin
        random_step();
      end
      drain_results();
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
src/osts_pkg.sv
src/osts_ctrl.sv
src/osts_dp.sv
src/one_shot_timeout_slot_table.sv
verif/osts_checker.sv
verif/testbench.sv
